### hw/rtl/gia_pkg.sv
// Shared types for the generational id allocator: controller states and control/status bundles.
package gia_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_EXEC
    } gia_state_t;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic load;     // capture the request
        logic rd_en;    // read the id table
        logic commit;   // decide, write back and present the result
    } gia_ctl_t;

    typedef struct packed {
        logic need_read;  // the request needs a table entry before it can finish
    } gia_sts_t;

endpackage

### hw/rtl/gia_ctrl.sv
// Controller state machine for the generational id allocator.
module gia_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gia_pkg::gia_sts_t sts,
    output logic              busy,
    output gia_pkg::gia_ctl_t ctl
);
    import gia_pkg::*;

    gia_state_t state_reg;
    gia_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                // fresh-slot allocates and table-full cases finish without a read
                if (sts.need_read)
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                ctl.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/gia_datapath.sv
// Datapath for the generational id allocator: id table, free list head, counters, result registers.
module gia_datapath #(
    parameter int CAPACITY   = 1024,
    parameter int INDEX_BITS = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  gia_pkg::gia_ctl_t ctl,
    output gia_pkg::gia_sts_t sts,
    input  logic              cmd,
    input  logic [31:0]       handle_in,
    output logic              done,
    output logic [31:0]       handle_out,
    output logic              released,
    output logic              exhausted
);
    import gia_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = INDEX_BITS;
    localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);
    localparam logic [31:0] GEN_MASK = ~IDX_MASK;
    localparam logic [31:0] GEN_STEP = 32'(64'd1 << INDEX_BITS);
    localparam logic [31:0] CAP32    = 32'(CAPACITY);

    logic [31:0]   id_mem [CAPACITY];

    logic          cmd_reg;
    logic [31:0]   handle_reg;
    logic [31:0]   rd_data_reg;
    logic [IW-1:0] free_head_reg;
    logic [IW-1:0] free_head_next;
    logic [CW-1:0] free_count_reg;
    logic [CW-1:0] free_count_next;
    logic [CW-1:0] used_slots_reg;
    logic [CW-1:0] used_slots_next;
    logic          done_reg;
    logic [31:0]   handle_out_reg;
    logic [31:0]   handle_out_next;
    logic          released_reg;
    logic          released_next;
    logic          exhausted_reg;
    logic          exhausted_next;

    logic [31:0]   head32;
    logic [31:0]   rel_idx32;
    logic [31:0]   used32;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          full;
    logic          match;

    assign head32    = 32'(free_head_reg);
    assign rel_idx32 = handle_reg & IDX_MASK;
    assign used32    = 32'(used_slots_reg);
    assign rd_addr   = (cmd_reg == CMD_RELEASE) ? rel_idx32[AW-1:0] : head32[AW-1:0];
    assign full      = (used32 == IDX_MASK) || (used32 >= CAP32);
    assign match     = (rel_idx32 < used32) && (rd_data_reg == handle_reg);

    assign sts.need_read = (cmd_reg == CMD_RELEASE) || (free_count_reg != '0);

    // capture request payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd;
            handle_reg <= handle_in;
        end
    end

    // id table, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= id_mem[rd_addr];
        end
        if (wr_en)
        begin
            id_mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        used_slots_next = used_slots_reg;
        handle_out_next = '0;
        released_next   = 1'b0;
        exhausted_next  = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = head32[AW-1:0];
        wr_data         = '0;
        if (cmd_reg == CMD_ALLOC)
        begin
            if (free_count_reg != '0)
            begin
                // pop the head, keep its stored generation
                wr_en           = 1'b1;
                wr_addr         = head32[AW-1:0];
                wr_data         = (head32 & IDX_MASK) | (rd_data_reg & GEN_MASK);
                free_head_next  = rd_data_reg[IW-1:0];
                free_count_next = free_count_reg - CW'(1);
                handle_out_next = (head32 & IDX_MASK) | (rd_data_reg & GEN_MASK);
            end
            else if (full)
            begin
                exhausted_next = 1'b1;
            end
            else
            begin
                // fresh slot at generation zero
                wr_en           = 1'b1;
                wr_addr         = used32[AW-1:0];
                wr_data         = used32;
                used_slots_next = used_slots_reg + CW'(1);
                handle_out_next = used32;
            end
        end
        else if (match)
        begin
            // bump generation, push slot on the free list
            wr_en           = 1'b1;
            wr_addr         = rel_idx32[AW-1:0];
            wr_data         = (head32 & IDX_MASK)
                            | (((handle_reg & GEN_MASK) + GEN_STEP) & GEN_MASK);
            free_head_next  = rel_idx32[IW-1:0];
            free_count_next = free_count_reg + CW'(1);
            released_next   = 1'b1;
        end
        if (!ctl.commit)
        begin
            wr_en           = 1'b0;
            free_head_next  = free_head_reg;
            free_count_next = free_count_reg;
            used_slots_next = used_slots_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '1;
            free_count_reg <= '0;
            used_slots_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            used_slots_reg <= used_slots_next;
            done_reg       <= ctl.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            handle_out_reg <= handle_out_next;
            released_reg   <= released_next;
            exhausted_reg  <= exhausted_next;
        end
    end

    assign done       = done_reg;
    assign handle_out = handle_out_reg;
    assign released   = released_reg;
    assign exhausted  = exhausted_reg;

endmodule

### hw/rtl/generational_id_allocator.sv
// Top level of the generational id allocator: controller plus datapath.
// An accepted request is captured, the id table is read when a release or the reuse of a
// freed slot needs an entry, and the result is committed; done is registered from the commit.
// The block takes no new request until the current one has committed, because of the single-port
// id table read-modify-write and the free head that the next request depends on.
// Reset (rst_n, async, active low) empties the free list and slot count; table contents
// stay undefined until written. done is a one-cycle strobe the receiver cannot stall.
module generational_id_allocator #(
    parameter int CAPACITY   = 1024,
    parameter int INDEX_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [31:0] handle_in,
    output logic        done,
    output logic [31:0] handle_out,
    output logic        released,
    output logic        exhausted
);
    import gia_pkg::*;

    gia_ctl_t ctl;
    gia_sts_t sts;

    // Sequence each transfer: capture, optional table read, commit.
    gia_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .ctl   (ctl)
    );

    // Hold the id table, the free list head and the slot counters; drive the result.
    gia_datapath #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cmd        (cmd),
        .handle_in  (handle_in),
        .done       (done),
        .handle_out (handle_out),
        .released   (released),
        .exhausted  (exhausted)
    );

    // An accepted request keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a request");

    // A result only follows a commit of the controller.
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl.commit))
        else $error("result strobe without a commit");

    // A result never both frees an id and reports exhaustion.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(released && exhausted))
        else $error("released and exhausted together");

    // A release or a failed allocate returns a zero id.
    a_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (released || exhausted)) |-> (handle_out == 32'd0))
        else $error("nonzero handle on release or exhaustion");

endmodule
